// File: rtl/core/hfve_pkg.sv
// ----------------------------------------------------------------------------
// hfve_pkg
// Shared types, constants and character helpers for the header field value
// extractor.
// ----------------------------------------------------------------------------
package hfve_pkg;

   localparam int KEY_BYTES_DEFAULT = 8;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_INDEX_W       = 2;
   localparam int KEY_LENGTH_W      = 4;
   localparam int VALUE_LIMIT_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_LIMIT = 2'd2;

   localparam logic [VALUE_LIMIT_W-1:0] VALUE_LIMIT_RESET = 8'd255;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_KEY    = 6'b000010,
      PH_SEEK   = 6'b000100,
      PH_SKIPV  = 6'b001000,
      PH_VALUE  = 6'b010000,
      PH_IGNORE = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_value;
      logic       finished;
      logic       found;
   } rsp_item_type;

   function automatic logic is_line_end(input logic [7:0] c);
      return c inside {CH_NUL, CH_CR, CH_LF};
   endfunction

   function automatic logic is_lead_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_COMMA, CH_TAB, CH_CR, CH_LF, CH_NUL};
   endfunction

   function automatic logic is_key_sep(input logic [7:0] c);
      return c inside {CH_COLON, CH_EQUAL, CH_TAB};
   endfunction

   function automatic logic is_value_sep(input logic [7:0] c);
      return c inside {CH_SPACE, CH_COLON, CH_EQUAL, CH_COMMA, CH_TAB};
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c inside {[CH_LOW_A:CH_LOW_Z]}) ? c - CASE_GAP : c;
   endfunction

endpackage

// File: rtl/core/hfve_cfg.sv
// ----------------------------------------------------------------------------
// hfve_cfg
// Configuration registers: key bytes, key length and value byte limit.
// ----------------------------------------------------------------------------
module hfve_cfg #(
   parameter int KEY_BYTES = hfve_pkg::KEY_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [hfve_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hfve_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [KEY_BYTES-1:0][7:0]             key_bytes,
   output logic [hfve_pkg::KEY_LENGTH_W-1:0]     key_length,
   output logic [hfve_pkg::VALUE_LIMIT_W-1:0]    value_limit
);
   import hfve_pkg::*;

   logic [KEY_BYTES-1:0][7:0]  key_ff, key_in;
   logic [KEY_LENGTH_W-1:0]    key_length_ff, key_length_in;
   logic [VALUE_LIMIT_W-1:0]   value_limit_ff, value_limit_in;

   always_comb begin
      key_in         = key_ff;
      key_length_in  = key_length_ff;
      value_limit_in = value_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_WORD:    key_in         = csr_wdata[KEY_BYTES*8-1:0];
            CSR_KEY_LENGTH:  key_length_in  = csr_wdata[KEY_LENGTH_W-1:0];
            CSR_VALUE_LIMIT: value_limit_in = csr_wdata[VALUE_LIMIT_W-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff         <= '0;
         key_length_ff  <= '0;
         value_limit_ff <= VALUE_LIMIT_RESET;
      end else begin
         key_ff         <= key_in;
         key_length_ff  <= key_length_in;
         value_limit_ff <= value_limit_in;
      end
   end

   assign key_bytes   = key_ff;
   assign key_length  = key_length_ff;
   assign value_limit = value_limit_ff;

endmodule

// File: rtl/core/hfve_scan.sv
// ----------------------------------------------------------------------------
// hfve_scan
// Per-byte line scanner: search state registers and the combinational
// decision that yields at most one result for each byte.
// ----------------------------------------------------------------------------
module hfve_scan #(
   parameter int KEY_BYTES = hfve_pkg::KEY_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  hfve_pkg::req_item_type             item,
   input  logic [KEY_BYTES-1:0][7:0]          key_bytes,
   input  logic [hfve_pkg::KEY_LENGTH_W-1:0]  key_length,
   input  logic [hfve_pkg::VALUE_LIMIT_W-1:0] value_limit,
   output logic                               res_valid,
   output hfve_pkg::rsp_item_type             res
);
   import hfve_pkg::*;

   localparam int KPOS_W = $clog2(KEY_BYTES + 1);
   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   phase_type                phase_ff, phase_in;
   logic [KPOS_W-1:0]        key_pos_ff, key_pos_in;
   logic                     key_mis_ff, key_mis_in;
   logic [VALUE_LIMIT_W-1:0] value_count_ff, value_count_in;
   logic                     search_done_ff, search_done_in;

   logic [KPOS_W-1:0] klen;
   logic [7:0]        c;
   logic              line_end;

   assign c        = item.text_byte;
   assign line_end = is_line_end(c);
   assign klen     = (key_length > KEY_LENGTH_W'(KEY_BYTES)) ? KPOS_W'(KEY_BYTES)
                                                              : KPOS_W'(key_length);

   always_comb begin
      logic used;
      logic matched;
      logic emit;
      logic fin;
      logic fnd;
      logic [7:0] kb;
      phase_in       = phase_ff;
      key_pos_in     = key_pos_ff;
      key_mis_in     = key_mis_ff;
      value_count_in = value_count_ff;
      search_done_in = search_done_ff;
      used           = 1'b0;
      matched        = 1'b0;
      emit           = 1'b0;
      fin            = 1'b0;
      fnd            = 1'b0;
      kb             = key_bytes[key_pos_ff[KIDX_W-1:0]];
      res            = '0;

      if (search_done_ff) begin
         // swallow the rest of the buffer, rearm on its last byte
         used = 1'b1;
         if (item.buffer_end) begin
            phase_in       = PH_LEAD;
            key_pos_in     = '0;
            key_mis_in     = 1'b0;
            value_count_in = '0;
            search_done_in = 1'b0;
         end
      end else begin
         if (phase_in == PH_IGNORE) begin
            used = 1'b1;
            if (line_end) phase_in = PH_LEAD;
         end
         if (!used && phase_in == PH_LEAD) begin
            if (is_lead_blank(c)) begin
               used = 1'b1;
            end else begin
               phase_in   = PH_KEY;
               key_pos_in = '0;
               key_mis_in = 1'b0;
               kb         = key_bytes[0];
            end
         end
         if (!used && phase_in == PH_KEY) begin
            if (key_pos_in >= klen) begin
               phase_in = PH_SEEK;
            end else begin
               used = 1'b1;
               if (line_end) begin
                  phase_in = PH_LEAD;
               end else begin
                  if (upcase(c) != upcase(kb)) key_mis_in = 1'b1;
                  key_pos_in = key_pos_in + KPOS_W'(1);
                  if (key_pos_in >= klen) phase_in = key_mis_in ? PH_IGNORE : PH_SEEK;
               end
            end
         end
         if (!used && phase_in == PH_SEEK) begin
            used = 1'b1;
            if (is_key_sep(c))  phase_in = PH_SKIPV;
            else if (line_end)  phase_in = PH_LEAD;
         end
         if (!used && phase_in == PH_SKIPV) begin
            if (is_value_sep(c)) begin
               used = 1'b1;
            end else if (line_end) begin
               used    = 1'b1;
               matched = 1'b1;
            end else begin
               phase_in       = PH_VALUE;
               value_count_in = '0;
            end
         end
         if (!used && phase_in == PH_VALUE) begin
            if (line_end) begin
               matched = 1'b1;
            end else if (value_count_in < value_limit) begin
               emit           = 1'b1;
               value_count_in = value_count_in + VALUE_LIMIT_W'(1);
            end
         end

         if (matched || item.buffer_end) begin
            fin = 1'b1;
            fnd = matched || phase_in == PH_SKIPV || phase_in == PH_VALUE;
            if (item.buffer_end) begin
               phase_in       = PH_LEAD;
               key_pos_in     = '0;
               key_mis_in     = 1'b0;
               value_count_in = '0;
               search_done_in = 1'b0;
            end else begin
               search_done_in = 1'b1;
            end
         end

         res.out_byte = emit ? c : 8'd0;
         res.is_value = emit;
         res.finished = fin;
         res.found    = fnd;
      end
      res_valid = step && (emit || fin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         key_pos_ff     <= '0;
         key_mis_ff     <= 1'b0;
         value_count_ff <= '0;
         search_done_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         key_pos_ff     <= key_pos_in;
         key_mis_ff     <= key_mis_in;
         value_count_ff <= value_count_in;
         search_done_ff <= search_done_in;
      end
   end

endmodule

// File: rtl/core/header_field_value_extractor_unit.sv
// Path: an accepted request is held in the input register, and its result is
//   then written to the result register, from which it is taken.
// Throughput: one request per cycle while the result channel does not stall.
// Reset: synchronous, active high; clears the search state, both channel
//   stages and the registers (key 0, key length 0, value limit 255).
// ----------------------------------------------------------------------------
// header_field_value_extractor_unit
// Streams text bytes, finds the first line led by the configured key and
// returns the value bytes of that line plus a closing found/not-found result.
// ----------------------------------------------------------------------------
module header_field_value_extractor_unit #(
   parameter int KEY_BYTES = hfve_pkg::KEY_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hfve_pkg::req_item_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hfve_pkg::rsp_item_type           rsp_data,
   input  logic                             csr_we,
   input  logic [hfve_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hfve_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hfve_pkg::*;

   logic                      in_valid_ff, in_valid_in;
   req_item_type              in_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_data_ff;
   logic                      advance;
   logic                      res_valid;
   rsp_item_type              res;
   logic [KEY_BYTES-1:0][7:0] key_bytes;
   logic [KEY_LENGTH_W-1:0]   key_length;
   logic [VALUE_LIMIT_W-1:0]  value_limit;

   hfve_cfg #(.KEY_BYTES(KEY_BYTES)) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .key_bytes   (key_bytes),
      .key_length  (key_length),
      .value_limit (value_limit)
   );

   hfve_scan #(.KEY_BYTES(KEY_BYTES)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .key_bytes   (key_bytes),
      .key_length  (key_length),
      .value_limit (value_limit),
      .res_valid   (res_valid),
      .res         (res)
   );

   // advance the held request once the result slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;

      if (advance) rsp_valid_in = res_valid;
      else         rsp_valid_in = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff  <= req_data;
      if (advance && res_valid)   rsp_data_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/hfve_checker.sv
// ----------------------------------------------------------------------------
// hfve_checker
// Port-level checks on the extractor's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hfve_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input hfve_pkg::rsp_item_type           rsp_data
);
   import hfve_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_value || rsp_data.finished)
      else $error("response carries neither a value byte nor a finish");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_value |-> rsp_data.out_byte == 8'd0)
      else $error("out_byte nonzero without a value byte");

   a_found_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.finished |-> !rsp_data.found)
      else $error("found raised without finished");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind header_field_value_extractor_unit hfve_checker u_hfve_checker (.*);
